FILE: design/table_search_engine_assert.svh
// ----------------------------------------------------------------------------
// Table search engine assertion macros
// Concurrent assertion helpers for the table search engine. The macros
// expand to nothing when the code is read by synthesis.
// ----------------------------------------------------------------------------
`ifndef TABLE_SEARCH_ENGINE_ASSERT_SVH
`define TABLE_SEARCH_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define TSE_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("table_search_engine: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TSE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("table_search_engine: assertion failed");

`else

`define TSE_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define TSE_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/tse_pkg.sv
// ----------------------------------------------------------------------------
// Table search engine package
// Sizes, codes, sequencer states and the control structs shared by the
// table search engine modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tse_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int HI_W        = CNT_W + 1;
    localparam int DATA_W      = 32;

    // Field widths fixed by the interface.
    localparam int SIZE_W      = 9;
    localparam int MODE_W      = 2;
    localparam int POS_W       = 8;
    localparam int CFG_IDX_W   = 1;

    // Packed stream payload widths.
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 8;

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = SIZE_W'(256);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TABLE_SIZE  = 1'b0,
        CFG_SEARCH_MODE = 1'b1
    } t_cfg_index;

    // Request kinds carried in the input tuser.
    typedef enum logic {
        REQ_WRITE  = 1'b0,
        REQ_SEARCH = 1'b1
    } t_req_type;

    // Search modes; bit 1 selects binary search.
    localparam logic [MODE_W-1:0] MODE_UNORDERED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ORDERED   = 2'd1;
    localparam int                MODE_BIN_BIT   = 1;

    // Search sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_BIN_ISSUE,
        ST_BIN_CMP,
        ST_DONE
    } t_state;

    // Search command handed to the sequencer.
    typedef struct packed {
        logic              start;
        logic              binary;
        logic              ordered;
        logic [CNT_W-1:0]  n;
        logic [DATA_W-1:0] key;
    } t_search_cmd;

    // Search result handed back by the sequencer.
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [ADDR_W-1:0] position;
    } t_search_res;

endpackage

`default_nettype wire

FILE: design/tse_entry_ram.sv
// ----------------------------------------------------------------------------
// Table search engine entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tse_entry_ram (
    input  wire logic                      i_clk,
    input  wire logic                      i_wr_en,
    input  wire logic [tse_pkg::ADDR_W-1:0] i_wr_addr,
    input  wire logic [tse_pkg::DATA_W-1:0] i_wr_data,
    input  wire logic [tse_pkg::ADDR_W-1:0] i_rd_addr,
    output logic      [tse_pkg::DATA_W-1:0] o_rd_data
);
    import tse_pkg::*;

    logic [DATA_W-1:0] r_mem [TABLE_DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: design/tse_search_seq.sv
// ----------------------------------------------------------------------------
// Table search engine sequencer
// Drives the memory read address and runs every entry read through one
// shared signed compare unit, for linear scans and for binary search.
// ----------------------------------------------------------------------------
`default_nettype none

module tse_search_seq (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire tse_pkg::t_search_cmd       i_cmd,
    input  wire logic [tse_pkg::DATA_W-1:0] i_rd_data,
    input  wire logic                       i_res_ready,
    output logic      [tse_pkg::ADDR_W-1:0] o_rd_addr,
    output logic                            o_idle,
    output tse_pkg::t_search_res            o_res
);
    import tse_pkg::*;

    t_state                    r_state, n_state;
    logic [DATA_W-1:0]         r_key, n_key;
    logic                      r_ordered, n_ordered;
    logic [CNT_W-1:0]          r_n, n_n;
    logic [CNT_W-1:0]          r_addr, n_addr;
    logic [ADDR_W-1:0]         r_cmp_addr, n_cmp_addr;
    logic                      r_rd_vld, n_rd_vld;
    logic [CNT_W-1:0]          r_lo, n_lo;
    logic signed [HI_W-1:0]    r_hi, n_hi;
    logic [ADDR_W-1:0]         r_mid, n_mid;
    logic                      r_found, n_found;
    logic [ADDR_W-1:0]         r_pos, n_pos;

    logic                      w_eq;
    logic                      w_gt;
    logic                      w_issue;
    logic                      w_stop;
    logic                      w_bin_open;
    logic signed [HI_W-1:0]    w_sum;
    logic [ADDR_W-1:0]         w_mid;

    // Shared compare unit: key against the entry just read.
    assign w_eq = (r_key == i_rd_data);
    assign w_gt = ($signed(r_key) > $signed(i_rd_data));

    // Linear scan helpers.
    assign w_issue = (r_addr < r_n);
    assign w_stop  = r_ordered ? !w_gt : w_eq;

    // Binary search helpers; the sum is never negative while lo <= hi.
    assign w_bin_open = ($signed({1'b0, r_lo}) <= r_hi);
    assign w_sum      = $signed({1'b0, r_lo}) + r_hi;
    assign w_mid      = w_sum[ADDR_W:1];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd.start) begin
                    n_state = i_cmd.binary ? ST_BIN_ISSUE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_rd_vld && w_stop) begin
                    n_state = ST_DONE;
                end else if (!r_rd_vld && !w_issue) begin
                    n_state = ST_DONE;
                end
            end
            ST_BIN_ISSUE: begin
                n_state = w_bin_open ? ST_BIN_CMP : ST_DONE;
            end
            ST_BIN_CMP: begin
                n_state = w_eq ? ST_DONE : ST_BIN_ISSUE;
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_key      = r_key;
        n_ordered  = r_ordered;
        n_n        = r_n;
        n_addr     = r_addr;
        n_cmp_addr = r_cmp_addr;
        n_rd_vld   = 1'b0;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_mid      = r_mid;
        n_found    = r_found;
        n_pos      = r_pos;
        o_rd_addr  = r_addr[ADDR_W-1:0];
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd.start) begin
                    n_key     = i_cmd.key;
                    n_ordered = i_cmd.ordered;
                    n_n       = i_cmd.n;
                    n_addr    = '0;
                    n_lo      = '0;
                    n_hi      = $signed({1'b0, i_cmd.n}) - HI_W'(1);
                    n_found   = 1'b0;
                    n_pos     = '0;
                end
            end
            ST_SCAN: begin
                // Read one entry a cycle; compare the entry read last cycle.
                n_rd_vld   = w_issue;
                n_cmp_addr = r_addr[ADDR_W-1:0];
                if (w_issue) begin
                    n_addr = r_addr + CNT_W'(1);
                end
                if (r_rd_vld && w_stop) begin
                    n_rd_vld = 1'b0;
                    n_found  = w_eq;
                    n_pos    = w_eq ? r_cmp_addr : '0;
                end
            end
            ST_BIN_ISSUE: begin
                o_rd_addr = w_mid;
                n_mid     = w_mid;
            end
            ST_BIN_CMP: begin
                o_rd_addr = r_mid;
                if (w_eq) begin
                    n_found = 1'b1;
                    n_pos   = r_mid;
                end else if (w_gt) begin
                    n_lo = CNT_W'(r_mid) + CNT_W'(1);
                end else begin
                    n_hi = $signed({1'b0, CNT_W'(r_mid)}) - HI_W'(1);
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= n_rd_vld;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_ordered  <= n_ordered;
        r_n        <= n_n;
        r_addr     <= n_addr;
        r_cmp_addr <= n_cmp_addr;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_found    <= n_found;
        r_pos      <= n_pos;
    end

    assign o_idle         = (r_state == ST_IDLE);
    assign o_res.valid    = (r_state == ST_DONE);
    assign o_res.found    = r_found;
    assign o_res.position = r_pos;

endmodule

`default_nettype wire

FILE: design/table_search_engine.sv
// ----------------------------------------------------------------------------
// Table search engine
// A table of signed 32-bit entries with linear and binary search.
// ----------------------------------------------------------------------------
// Usage:
//   The s_axis channel takes requests. tuser holds the request kind: a write
//   stores tdata's value at tdata's index, a search looks up tdata's key.
//   The m_axis channel gives one result per search: tuser is found and
//   tdata the zero-based position (zero when not found). Writes give none.
//   The cfg channel writes table_size (index 0) and search_mode (index 1);
//   it is always ready. The user must write it only while no search is in
//   flight; the block does not enforce this.
// Request flow:
//   Writes are taken every cycle while no search runs. A linear search
//   makes one memory read and one compare of the shared compare unit per
//   entry, over up to n entries, n being the table size capped at the table
//   depth. A binary search probe takes an issue state and a compare state.
//   The block is not ready while a search runs.
// Reset and stalls:
//   Reset sets table_size to 256 and search_mode to unordered linear; the
//   table contents are undefined until written. A finished result waits in
//   the output register; while the receiver stalls, writes are still taken,
//   and a further search holds in its last cycle until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

`include "table_search_engine_assert.svh"

module table_search_engine (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Request channel.
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: entry_index [7:0], entry_value [39:8], search_key [71:40]
    input  wire logic [tse_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // tuser: req_type [0]
    input  wire logic                             s_axis_tuser,
    // Result channel.
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // tdata: position [7:0]
    output logic      [tse_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // tuser: found [0]
    output logic                                  m_axis_tuser,
    // Configuration write channel.
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [tse_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [tse_pkg::SIZE_W-1:0]       i_cfg_data
);
    import tse_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    logic [SIZE_W-1:0]  r_table_size;
    logic [MODE_W-1:0]  r_search_mode;
    logic               r_m_valid;
    logic               r_m_found;
    logic [POS_W-1:0]   r_m_pos;

    logic               w_in_xfer;
    logic               w_cfg_xfer;
    logic               w_out_free;
    logic               w_seq_idle;
    logic [CNT_W-1:0]   w_n;
    logic [ADDR_W-1:0]  w_entry_index;
    logic [DATA_W-1:0]  w_entry_value;
    logic [DATA_W-1:0]  w_search_key;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic [DATA_W-1:0]  w_rd_data;
    t_req_type          w_req;
    t_search_cmd        w_cmd;
    t_search_res        w_res;

    // Unpack the request payload.
    assign w_req         = t_req_type'(s_axis_tuser);
    assign w_entry_index = s_axis_tdata[ADDR_W-1:0];
    assign w_entry_value = s_axis_tdata[39:8];
    assign w_search_key  = s_axis_tdata[71:40];

    assign s_axis_tready = w_seq_idle;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign w_cfg_xfer    = i_cfg_valid && o_cfg_ready;
    assign w_out_free    = !r_m_valid || m_axis_tready;

    // Entries searched, capped at the table depth.
    assign w_n = (32'(r_table_size) > TABLE_DEPTH) ? DEPTH_CNT : CNT_W'(r_table_size);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size  <= TABLE_SIZE_RST;
            r_search_mode <= MODE_UNORDERED;
        end else if (w_cfg_xfer) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_TABLE_SIZE:  r_table_size  <= i_cfg_data;
                CFG_SEARCH_MODE: r_search_mode <= i_cfg_data[MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Search command to the sequencer.
    assign w_cmd.start   = w_in_xfer && (w_req == REQ_SEARCH);
    assign w_cmd.binary  = r_search_mode[MODE_BIN_BIT];
    assign w_cmd.ordered = (r_search_mode == MODE_ORDERED);
    assign w_cmd.n       = w_n;
    assign w_cmd.key     = w_search_key;

    tse_entry_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_in_xfer && (w_req == REQ_WRITE)),
        .i_wr_addr (w_entry_index),
        .i_wr_data (w_entry_value),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    tse_search_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_rd_data   (w_rd_data),
        .i_res_ready (w_out_free),
        .o_rd_addr   (w_rd_addr),
        .o_idle      (w_seq_idle),
        .o_res       (w_res)
    );

    // Output register; loads a finished result when it is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_out_free) begin
            r_m_valid <= w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_res.valid) begin
            r_m_found <= w_res.found;
            r_m_pos   <= POS_W'(w_res.position);
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_found;
    assign m_axis_tdata  = r_m_pos;

    // A result that is not found reports position zero.
    `TSE_ASSERT_IMPLY(a_miss_pos_zero, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)

    // A found position lies inside the searched part of the table.
    `TSE_ASSERT_IMPLY(a_hit_in_range, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser, CNT_W'(m_axis_tdata) < w_n)

    // An accepted search closes the request channel in the next cycle.
    `TSE_ASSERT_NEXT(a_search_busy, i_clk, i_rst_n,
        w_in_xfer && (w_req == REQ_SEARCH), !s_axis_tready)

    // An accepted write never produces a result of its own.
    `TSE_ASSERT_NEXT(a_write_no_result, i_clk, i_rst_n,
        w_in_xfer && (w_req == REQ_WRITE) && !m_axis_tvalid, !m_axis_tvalid)

endmodule

`default_nettype wire
